@@ rtl/core/sbtq_pkg.sv @@
`timescale 1ns / 1ps

package sbtq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_DISPATCH = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    localparam int unsigned TIME_W  = 16;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned TOTAL_W = 20;

    typedef struct packed {
        t_op                 operation;
        logic [TIME_W-1:0]   burst_time;
    } t_in_word;

    typedef struct packed {
        t_status             status;
        logic [COUNT_W-1:0]  entry_count;
        logic [TIME_W-1:0]   shortest_time;
        logic [TOTAL_W-1:0]  total_time;
    } t_out_word;

    // per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

@@ rtl/core/sbtq_cell.sv @@
`timescale 1ns / 1ps

module sbtq_cell #(
    parameter int unsigned TIME_BITS = 16
) (
    input  logic                 i_clk,
    input  sbtq_pkg::t_cell_ctrl i_ctrl,
    input  logic [TIME_BITS-1:0] i_value,
    input  logic                 i_occ,
    input  logic                 i_prev_lt,
    input  logic [TIME_BITS-1:0] i_prev_entry,
    input  logic [TIME_BITS-1:0] i_next_entry,
    output logic [TIME_BITS-1:0] o_entry,
    output logic                 o_lt,
    output logic                 o_le,
    output logic                 o_match
);
    import sbtq_pkg::*;

    logic [TIME_BITS-1:0] r_entry;
    logic [TIME_BITS-1:0] n_entry;

    assign o_entry = r_entry;
    assign o_lt    = i_occ && (i_value < r_entry);
    assign o_le    = i_occ && (r_entry <= i_value);
    assign o_match = i_occ && (r_entry == i_value);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            // cells ahead of the slot keep; the slot takes the value; the rest shift down
            if (!o_lt) begin
                n_entry = i_prev_lt ? i_value : i_prev_entry;
            end
        end else if (i_ctrl.del) begin
            // from the first match onwards, pull from the neighbour behind
            if (o_le) begin
                n_entry = i_next_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ rtl/core/sorted_burst_time_queue_top.sv @@
`timescale 1ns / 1ps

// Sorted burst-time queue for shortest-job-first dispatch.
// Input channel (i_in_valid / o_in_stall / i_in_word): one word is an operation
// (insert, delete, dispatch-all) with a burst time. Output channel (o_out_valid /
// i_out_stall / o_out_word): exactly one result word per input word, in order,
// carrying status, entry count, smallest held entry and, on dispatch, the total.
// Entries live in a row of DEPTH cells kept largest-first. On insert every cell
// compares against the new value and either holds, takes the value or takes its
// neighbour's entry; on delete cells from the first match onwards pull from the
// neighbour behind. A running total register gives the dispatch sum at once.
// The row updates at the accept edge and the result word is registered on the
// following edge, so o_out_valid rises in the cycle after acceptance.
// The input takes no new word until the pending result has moved to the output
// register, which reads the tail of the freshly updated row.
// Reset (i_rst_n low, synchronous) empties the queue and drops any pending result;
// cell contents are not cleared and are never read before being written.
// A stalled output holds its word; the input is stalled while a result is pending,
// and also while a finished word sits stalled in the output register.
module sorted_burst_time_queue_top #(
    parameter int unsigned DEPTH     = 16,
    parameter int unsigned TIME_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sbtq_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sbtq_pkg::t_out_word o_out_word
);
    import sbtq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = TIME_BITS + CW;

    // queue state
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [SW-1:0]        r_total;
    logic [SW-1:0]        n_total;

    // pending result, waiting for the row read-back
    logic                 r_pend;
    t_status              r_status;
    t_status              n_status;
    logic [TOTAL_W-1:0]   r_total_res;
    logic [TOTAL_W-1:0]   n_total_res;

    logic                 r_out_valid;
    t_out_word            r_out_word;

    logic                 acc;
    logic                 load_out;
    logic [TIME_BITS-1:0] value;
    t_cell_ctrl           ctrl;

    logic [DEPTH-1:0]     occ;
    logic [DEPTH-1:0]     lt;
    logic [DEPTH-1:0]     le;
    logic [DEPTH-1:0]     match;
    logic [TIME_BITS-1:0] entry [DEPTH];
    logic                 found;
    logic                 full;
    logic                 empty;
    logic [TIME_BITS-1:0] shortest;

    assign value    = TIME_BITS'(i_in_word.burst_time);
    assign acc      = i_in_valid && !o_in_stall;
    assign load_out = r_pend && (!r_out_valid || !i_out_stall);
    assign found    = |match;
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);

    assign o_in_stall  = r_pend || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // cell row
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                 prev_lt;
        logic [TIME_BITS-1:0] prev_entry;
        logic [TIME_BITS-1:0] next_entry;

        assign occ[gi] = (CW'(gi) < r_count);

        if (gi == 0) begin : g_head
            assign prev_lt    = 1'b1;
            assign prev_entry = value;
        end else begin : g_mid
            assign prev_lt    = lt[gi-1];
            assign prev_entry = entry[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign next_entry = entry[gi];
        end else begin : g_body
            assign next_entry = entry[gi+1];
        end

        sbtq_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_value      (value),
            .i_occ        (occ[gi]),
            .i_prev_lt    (prev_lt),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .o_entry      (entry[gi]),
            .o_lt         (lt[gi]),
            .o_le         (le[gi]),
            .o_match      (match[gi])
        );
    end

    // operation decode
    always_comb begin
        ctrl        = '0;
        n_count     = r_count;
        n_total     = r_total;
        n_status    = ST_OK;
        n_total_res = '0;
        case (i_in_word.operation)
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    ctrl.ins = acc;
                    n_count  = r_count + CW'(1);
                    n_total  = r_total + SW'(value);
                end
            end
            OP_DELETE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    ctrl.del = acc;
                    n_count  = r_count - CW'(1);
                    n_total  = r_total - SW'(value);
                end
            end
            OP_DISPATCH: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_total_res = TOTAL_W'(r_total);
                    n_count     = '0;
                    n_total     = '0;
                end
            end
            default: begin
                // spare code: no change, plain report
            end
        endcase
    end

    // tail of the row: the occupied cell whose successor is empty
    always_comb begin
        shortest = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (occ[k] && ((k == DEPTH - 1) || !occ[(k + 1) % DEPTH])) begin
                shortest = shortest | entry[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_total     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_count <= n_count;
                r_total <= n_total;
                r_pend  <= 1'b1;
            end else if (load_out) begin
                r_pend  <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status    <= n_status;
            r_total_res <= n_total_res;
        end
        if (load_out) begin
            r_out_word.status        <= r_status;
            r_out_word.entry_count   <= COUNT_W'(r_count);
            r_out_word.shortest_time <= TIME_W'(shortest);
            r_out_word.total_time    <= r_total_res;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_accept_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_pend)
        else $error("accepted word left no pending result");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("running total non-zero with empty queue");

    a_pend_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> o_in_stall)
        else $error("input open while a result is pending");

endmodule
